// File: src/vvr_pkg.sv
package vvr_pkg;

    localparam int DATA_W        = 64;
    localparam int MASS_W        = 63;
    localparam int STEP_W        = 11;
    localparam int ADDR_W        = 6;
    localparam int FRAC_BITS_DEF = 32;

    localparam logic [DATA_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] SMIN = 64'h8000_0000_0000_0000;

    // register index, byte address is 8 times this
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_THREE_BODY  = 3'd1;
    localparam logic [2:0] REG_RESPA_STEPS = 3'd2;
    localparam logic [2:0] REG_OUTER_RESPA = 3'd3;
    localparam logic [2:0] REG_GLOBAL_X    = 3'd4;
    localparam logic [2:0] REG_GLOBAL_Y    = 3'd5;
    localparam logic [2:0] REG_GLOBAL_Z    = 3'd6;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_POS,
        KIND_VEL,
        KIND_OUTER
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] pair;
        logic [DATA_W-1:0] triple;
        logic [DATA_W-1:0] prev;
    } side_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] d;
        logic              neg;
        logic              ovf;
        logic              nz;
        logic [DATA_W-1:0] a;
        side_t             side;
    } div_stage_t;

    function automatic logic [DATA_W-1:0] sat_add(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
        logic [DATA_W-1:0] r;
        r = x + y;
        if (x[DATA_W-1] == y[DATA_W-1] && r[DATA_W-1] != x[DATA_W-1])
        begin
            r = x[DATA_W-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag(logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [2*DATA_W-1:0] mul_join(logic [DATA_W-1:0] p00,
                                                     logic [DATA_W-1:0] p01,
                                                     logic [DATA_W-1:0] p10,
                                                     logic [DATA_W-1:0] p11);
        return {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    endfunction

    function automatic logic [DATA_W-1:0] sat_mag(logic [2*DATA_W-1:0] m, logic neg);
        logic [DATA_W-1:0] r;
        if (neg)
        begin
            r = (m > {64'd0, SMIN}) ? SMIN : (~m[DATA_W-1:0] + 64'd1);
        end
        else
        begin
            r = (m > {64'd0, SMAX}) ? SMAX : m[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/vvr_in_if.sv
interface vvr_in_if;
    import vvr_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [1:0]          axis;
    logic                skip;
    logic [MASS_W-1:0]   mass;
    logic [DATA_W-1:0]   in_position;
    logic [DATA_W-1:0]   in_velocity;
    logic [DATA_W-1:0]   in_pair_force;
    logic [DATA_W-1:0]   in_triple_force;
    logic [DATA_W-1:0]   in_previous_force;

    modport source (
        output valid, mode, axis, skip, mass, in_position, in_velocity,
               in_pair_force, in_triple_force, in_previous_force,
        input  ready
    );

    modport sink (
        input  valid, mode, axis, skip, mass, in_position, in_velocity,
               in_pair_force, in_triple_force, in_previous_force,
        output ready
    );
endinterface

// File: src/vvr_out_if.sv
interface vvr_out_if;
    import vvr_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   out_position;
    logic [DATA_W-1:0]   out_velocity;
    logic [DATA_W-1:0]   out_pair_force;
    logic [DATA_W-1:0]   out_triple_force;
    logic [DATA_W-1:0]   out_previous_force;

    modport source (
        output valid, out_position, out_velocity, out_pair_force,
               out_triple_force, out_previous_force,
        input  ready
    );

    modport sink (
        input  valid, out_position, out_velocity, out_pair_force,
               out_triple_force, out_previous_force,
        output ready
    );
endinterface

// File: src/velocity_verlet_respa_particle_update.sv
// throughput: one item per cycle while the output is not stalled, the whole pipeline advances together
// the divider takes one quotient bit per stage over 64 stages and sets the depth
// a stalled output holds every stage, no item is lost or repeated
// rst_n clears all valid bits and config registers asynchronously
module velocity_verlet_respa_particle_update #(
    parameter int FRAC_BITS = vvr_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    vvr_in_if.sink                      in_ch,
    vvr_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vvr_pkg::ADDR_W-1:0]  paddr,
    input  logic [vvr_pkg::DATA_W-1:0]  pwdata,
    output logic [vvr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import vvr_pkg::*;

    localparam int DIV_STEPS = DATA_W;

    // configuration
    logic [MASS_W-1:0] time_step_reg;
    logic              three_body_reg;
    logic [STEP_W-1:0] respa_steps_reg;
    logic              outer_respa_reg;
    logic [DATA_W-1:0] global_x_reg;
    logic [DATA_W-1:0] global_y_reg;
    logic [DATA_W-1:0] global_z_reg;
    logic [2:0]        reg_sel;
    logic [DATA_W-1:0] dt;

    assign pready  = 1'b1;
    assign reg_sel = paddr[5:3];
    assign dt      = {1'b0, time_step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= '0;
            three_body_reg  <= 1'b0;
            respa_steps_reg <= '0;
            outer_respa_reg <= 1'b0;
            global_x_reg    <= '0;
            global_y_reg    <= '0;
            global_z_reg    <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_TIME_STEP:   time_step_reg   <= pwdata[MASS_W-1:0];
                REG_THREE_BODY:  three_body_reg  <= pwdata[0];
                REG_RESPA_STEPS: respa_steps_reg <= pwdata[STEP_W-1:0];
                REG_OUTER_RESPA: outer_respa_reg <= pwdata[0];
                REG_GLOBAL_X:    global_x_reg    <= pwdata;
                REG_GLOBAL_Y:    global_y_reg    <= pwdata;
                REG_GLOBAL_Z:    global_z_reg    <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TIME_STEP:   prdata = {1'b0, time_step_reg};
            REG_THREE_BODY:  prdata = {63'd0, three_body_reg};
            REG_RESPA_STEPS: prdata = {53'd0, respa_steps_reg};
            REG_OUTER_RESPA: prdata = {63'd0, outer_respa_reg};
            REG_GLOBAL_X:    prdata = global_x_reg;
            REG_GLOBAL_Y:    prdata = global_y_reg;
            REG_GLOBAL_Z:    prdata = global_z_reg;
            default:         prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic v1_reg, v2_reg, v5_reg, v6_reg, v7_reg, ov_reg;
    logic [DIV_STEPS:0] dv_valid_reg;

    assign en          = !ov_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: operand select
    logic [DATA_W-1:0] total, s_plain, s_inner, num, gforce;
    kind_t             kind_in;
    side_t             side_in;

    always_comb
    begin
        total   = three_body_reg ? sat_add(in_ch.in_pair_force, in_ch.in_triple_force)
                                 : in_ch.in_pair_force;
        s_plain = sat_add(sat_add(in_ch.in_pair_force, in_ch.in_triple_force),
                          in_ch.in_previous_force);
        s_inner = sat_add(in_ch.in_pair_force, in_ch.in_previous_force);
        unique case (in_ch.axis)
            2'd0:    gforce = global_x_reg;
            2'd1:    gforce = global_y_reg;
            2'd2:    gforce = global_z_reg;
            default: gforce = '0;
        endcase
        priority if (in_ch.skip)
        begin
            kind_in = KIND_PASS;
            num     = total;
        end
        else if (!in_ch.mode)
        begin
            kind_in = KIND_POS;
            num     = total;
        end
        else if (respa_steps_reg == '0)
        begin
            kind_in = KIND_VEL;
            num     = s_plain;
        end
        else if (!outer_respa_reg)
        begin
            kind_in = KIND_VEL;
            num     = s_inner;
        end
        else
        begin
            kind_in = KIND_OUTER;
            num     = in_ch.in_triple_force;
        end
        side_in.kind = kind_in;
        side_in.pos  = in_ch.in_position;
        side_in.vel  = in_ch.in_velocity;
        if (kind_in == KIND_POS)
        begin
            side_in.pair   = gforce;
            side_in.triple = '0;
            side_in.prev   = total;
        end
        else
        begin
            side_in.pair   = in_ch.in_pair_force;
            side_in.triple = in_ch.in_triple_force;
            side_in.prev   = in_ch.in_previous_force;
        end
    end

    logic [DATA_W-1:0] num_mag_1, vel_mag_1, d_1;
    logic              num_neg_1, vel_neg_1;
    side_t             side_1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_ch.valid;
            num_mag_1 <= mag(num);
            num_neg_1 <= num[DATA_W-1];
            vel_mag_1 <= mag(in_ch.in_velocity);
            vel_neg_1 <= in_ch.in_velocity[DATA_W-1];
            d_1       <= {in_ch.mass, 1'b0};
            side_1    <= side_in;
        end
    end

    // stage 2: partial products of num*dt and vel*dt
    logic [DATA_W-1:0] pn_reg [4];
    logic [DATA_W-1:0] pv_reg [4];
    logic [DATA_W-1:0] d_2;
    logic              num_neg_2, vel_neg_2;
    side_t             side_2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg    <= v1_reg;
            pn_reg[0] <= num_mag_1[31:0]  * dt[31:0];
            pn_reg[1] <= num_mag_1[31:0]  * dt[63:32];
            pn_reg[2] <= num_mag_1[63:32] * dt[31:0];
            pn_reg[3] <= num_mag_1[63:32] * dt[63:32];
            pv_reg[0] <= vel_mag_1[31:0]  * dt[31:0];
            pv_reg[1] <= vel_mag_1[31:0]  * dt[63:32];
            pv_reg[2] <= vel_mag_1[63:32] * dt[31:0];
            pv_reg[3] <= vel_mag_1[63:32] * dt[63:32];
            d_2       <= d_1;
            num_neg_2 <= num_neg_1;
            vel_neg_2 <= vel_neg_1;
            side_2    <= side_1;
        end
    end

    // stage 3: join products, v*dt term, divider setup
    logic [2*DATA_W-1:0] prod_n, prod_v;
    div_stage_t          dv_in;

    always_comb
    begin
        prod_n = mul_join(pn_reg[0], pn_reg[1], pn_reg[2], pn_reg[3]);
        prod_v = mul_join(pv_reg[0], pv_reg[1], pv_reg[2], pv_reg[3]);
        dv_in.rem  = prod_n[2*DATA_W-1:DATA_W];
        dv_in.w    = prod_n[DATA_W-1:0];
        dv_in.d    = d_2;
        dv_in.neg  = num_neg_2;
        // quotient needs more than 64 bits, also covers a zero divisor
        dv_in.ovf  = prod_n[2*DATA_W-1:DATA_W] >= d_2;
        dv_in.nz   = prod_n == '0;
        dv_in.a    = sat_mag(prod_v >> FRAC_BITS, vel_neg_2);
        dv_in.side = side_2;
    end

    // stages 4 to 67: restoring divider, one quotient bit per stage
    div_stage_t dv_reg  [DIV_STEPS+1];
    div_stage_t dv_next [DIV_STEPS];

    always_comb
    begin
        logic [DATA_W:0] t;
        logic [DATA_W:0] diff;
        logic            ge;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t    = {dv_reg[k].rem, dv_reg[k].w[DATA_W-1]};
            diff = t - {1'b0, dv_reg[k].d};
            ge   = t >= {1'b0, dv_reg[k].d};
            dv_next[k]     = dv_reg[k];
            dv_next[k].rem = ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];
            dv_next[k].w   = {dv_reg[k].w[DATA_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (en)
        begin
            dv_valid_reg <= {dv_valid_reg[DIV_STEPS-1:0], v2_reg};
            dv_reg[0]    <= dv_in;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_reg[k+1] <= dv_next[k];
            end
        end
    end

    // stage 68: quotient magnitude with saturation, second multiplier operand
    div_stage_t        last;
    logic [DATA_W-1:0] qmag_c, u2_c;

    always_comb
    begin
        last = dv_reg[DIV_STEPS];
        priority if (last.nz)
        begin
            qmag_c = '0;
        end
        else if (last.ovf)
        begin
            qmag_c = last.neg ? SMIN : SMAX;
        end
        else if (last.neg && last.w > SMIN)
        begin
            qmag_c = SMIN;
        end
        else if (!last.neg && last.w > SMAX)
        begin
            qmag_c = SMAX;
        end
        else
        begin
            qmag_c = last.w;
        end
        u2_c = (last.side.kind == KIND_OUTER)
             ? ({53'd0, respa_steps_reg} << FRAC_BITS) : dt;
    end

    logic [DATA_W-1:0] qmag_5, u2_5, a_5;
    logic              qneg_5;
    side_t             side_5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= dv_valid_reg[DIV_STEPS];
            qmag_5 <= qmag_c;
            qneg_5 <= last.neg;
            u2_5   <= u2_c;
            a_5    <= last.a;
            side_5 <= last.side;
        end
    end

    // stage 69: partial products of q*dt or q*steps
    logic [DATA_W-1:0] pq_reg [4];
    logic [DATA_W-1:0] qmag_6, a_6;
    logic              qneg_6;
    side_t             side_6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg    <= v5_reg;
            pq_reg[0] <= qmag_5[31:0]  * u2_5[31:0];
            pq_reg[1] <= qmag_5[31:0]  * u2_5[63:32];
            pq_reg[2] <= qmag_5[63:32] * u2_5[31:0];
            pq_reg[3] <= qmag_5[63:32] * u2_5[63:32];
            qmag_6    <= qmag_5;
            qneg_6    <= qneg_5;
            a_6       <= a_5;
            side_6    <= side_5;
        end
    end

    // stage 70: join, shift and saturate the second product
    logic [DATA_W-1:0] b_7, qmag_7, a_7;
    logic              qneg_7;
    side_t             side_7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= v6_reg;
            b_7    <= sat_mag(mul_join(pq_reg[0], pq_reg[1], pq_reg[2], pq_reg[3])
                              >> FRAC_BITS, qneg_6);
            qmag_7 <= qmag_6;
            qneg_7 <= qneg_6;
            a_7    <= a_6;
            side_7 <= side_6;
        end
    end

    // stage 71: final saturated adds into the output register
    logic [DATA_W-1:0] q_7, pos_c, vel_c;

    always_comb
    begin
        q_7   = qneg_7 ? (~qmag_7 + 64'd1) : qmag_7;
        pos_c = side_7.pos;
        vel_c = side_7.vel;
        unique case (side_7.kind)
            KIND_POS:   pos_c = sat_add(side_7.pos, sat_add(a_7, b_7));
            KIND_VEL:   vel_c = sat_add(side_7.vel, q_7);
            KIND_OUTER: vel_c = sat_add(side_7.vel, b_7);
            KIND_PASS:  ;
        endcase
    end

    logic [DATA_W-1:0] pos_out_reg, vel_out_reg, pair_out_reg, triple_out_reg, prev_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg         <= v7_reg;
            pos_out_reg    <= pos_c;
            vel_out_reg    <= vel_c;
            pair_out_reg   <= side_7.pair;
            triple_out_reg <= side_7.triple;
            prev_out_reg   <= side_7.prev;
        end
    end

    assign out_ch.valid              = ov_reg;
    assign out_ch.out_position       = pos_out_reg;
    assign out_ch.out_velocity       = vel_out_reg;
    assign out_ch.out_pair_force     = pair_out_reg;
    assign out_ch.out_triple_force   = triple_out_reg;
    assign out_ch.out_previous_force = prev_out_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> v1_reg)
        else $error("accepted item did not enter stage one");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_valid_reg[DIV_STEPS]) |=> v5_reg)
        else $error("item lost leaving the divider");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (v1_reg == $past(v1_reg) && dv_valid_reg == $past(dv_valid_reg)))
        else $error("pipeline moved during a stall");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v7_reg && side_7.kind == KIND_PASS)
        |=> (out_ch.out_position == $past(side_7.pos)
             && out_ch.out_velocity == $past(side_7.vel)))
        else $error("dummy item changed");

endmodule

// File: verif/tb_velocity_verlet_respa_particle_update.sv
module tb_velocity_verlet_respa_particle_update;
    import vvr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 70;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic              mode;
        logic [1:0]        axis;
        logic              skip;
        logic [MASS_W-1:0] mass;
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] pair;
        logic [DATA_W-1:0] triple;
        logic [DATA_W-1:0] prev;
    } particle_t;

    typedef struct packed {
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] pair;
        logic [DATA_W-1:0] triple;
        logic [DATA_W-1:0] prev;
    } update_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    vvr_in_if in_ch ();
    vvr_out_if out_ch ();

    velocity_verlet_respa_particle_update dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [MASS_W-1:0] step_dt;
    logic              three_body_on;
    logic [10:0]       n_respa;
    logic              outer_on;
    logic [DATA_W-1:0] global_f [3];

    particle_t pending_items [$];
    update_t   expected_updates [$];
    int errors;
    int idle_cycles;
    int n_sent;
    int n_checked;
    bit hold_off_req;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [DATA_W-1:0] sat_sum(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
        logic [DATA_W-1:0] r;
        r = x + y;
        if (x[63] == y[63] && r[63] != x[63])
        begin
            r = x[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] clamp_signed(logic [127:0] m, logic neg);
        if (neg)
        begin
            return (m > {64'd0, SMIN}) ? SMIN : (~m[63:0] + 64'd1);
        end
        return (m > {64'd0, SMAX}) ? SMAX : m[63:0];
    endfunction

    function automatic logic [DATA_W-1:0] scale_fixed(logic [DATA_W-1:0] s, logic [DATA_W-1:0] u);
        logic neg;
        logic [63:0] m;
        logic [127:0] p;
        neg = s[63];
        m = neg ? -s : s;
        p = {64'd0, m} * {64'd0, u};
        return clamp_signed(p >> 32, neg);
    endfunction

    function automatic logic [DATA_W-1:0] kick_div(logic [DATA_W-1:0] s, logic [DATA_W-1:0] u,
                                                    logic [DATA_W-1:0] d);
        logic neg;
        logic [63:0] m;
        logic [127:0] p;
        neg = s[63];
        m = neg ? -s : s;
        p = {64'd0, m} * {64'd0, u};
        if (d == 0)
        begin
            if (p == 0)
            begin
                return 64'd0;
            end
            return neg ? SMIN : SMAX;
        end
        return clamp_signed(p / {64'd0, d}, neg);
    endfunction

    function automatic update_t integrate(particle_t it);
        update_t r;
        logic [DATA_W-1:0] dt;
        logic [DATA_W-1:0] two_m;
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] q;
        dt = {1'b0, step_dt};
        two_m = {it.mass, 1'b0};
        r.pos = it.pos;
        r.vel = it.vel;
        r.pair = it.pair;
        r.triple = it.triple;
        r.prev = it.prev;
        if (it.skip)
        begin
            return r;
        end
        if (!it.mode)
        begin
            total = three_body_on ? sat_sum(it.pair, it.triple) : it.pair;
            q = kick_div(total, dt, two_m);
            r.pos = sat_sum(it.pos, sat_sum(scale_fixed(it.vel, dt), scale_fixed(q, dt)));
            r.prev = total;
            r.pair = (it.axis == 2'd3) ? 64'd0 : global_f[it.axis];
            r.triple = 64'd0;
        end
        else if (n_respa == 0)
        begin
            s = sat_sum(sat_sum(it.pair, it.triple), it.prev);
            r.vel = sat_sum(it.vel, kick_div(s, dt, two_m));
        end
        else if (!outer_on)
        begin
            s = sat_sum(it.pair, it.prev);
            r.vel = sat_sum(it.vel, kick_div(s, dt, two_m));
        end
        else
        begin
            q = kick_div(it.triple, dt, two_m);
            r.vel = sat_sum(it.vel, scale_fixed(q, {21'd0, n_respa, 32'd0}));
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TIME_STEP:   step_dt = value[MASS_W-1:0];
            REG_THREE_BODY:  three_body_on = value[0];
            REG_RESPA_STEPS: n_respa = value[10:0];
            REG_OUTER_RESPA: outer_on = value[0];
            REG_GLOBAL_X:    global_f[0] = value;
            REG_GLOBAL_Y:    global_f[1] = value;
            REG_GLOBAL_Z:    global_f[2] = value;
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = SMAX;
            1: w = SMIN;
            2: w = 64'd0;
            3: w = {{32{w[63]}}, w[31:0]};
            4: w = {{40{w[63]}}, w[23:0]};
            default: ;
        endcase
        return w;
    endfunction

    function automatic particle_t rand_particle();
        particle_t it;
        it.mode = 1'($urandom_range(0, 1));
        it.axis = 2'($urandom_range(0, 3));
        it.skip = ($urandom_range(0, 9) == 0);
        it.mass = ($urandom_range(0, 3) == 0) ? MASS_W'({$urandom, $urandom})
                                              : {5'd0, $urandom_range(1, 64), 26'd0};
        if ($urandom_range(0, 20) == 0)
        begin
            it.mass = '0;
        end
        it.pos = rand_word();
        it.vel = rand_word();
        it.pair = rand_word();
        it.triple = rand_word();
        it.prev = rand_word();
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_updates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic run_batch(int count);
        for (int i = 0; i < count; i++)
        begin
            pending_items.push_back(rand_particle());
        end
        wait_drained();
    endtask

    // driver
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_updates.push_back(integrate(pending_items.pop_front()));
                n_sent++;
                gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                // keep offering the same item
            end
            else if (gap_left > 0 && !(in_ch.valid && in_ch.ready))
            begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0 && !(in_ch.valid && in_ch.ready && gap_left != 0))
            begin
                if (in_ch.valid && in_ch.ready && pending_items.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.mode <= pending_items[0].mode;
                    in_ch.axis <= pending_items[0].axis;
                    in_ch.skip <= pending_items[0].skip;
                    in_ch.mass <= pending_items[0].mass;
                    in_ch.in_position <= pending_items[0].pos;
                    in_ch.in_velocity <= pending_items[0].vel;
                    in_ch.in_pair_force <= pending_items[0].pair;
                    in_ch.in_triple_force <= pending_items[0].triple;
                    in_ch.in_previous_force <= pending_items[0].prev;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int stall_left;
    int hold_count;
    always @(posedge clk or negedge rst_n)
    begin
        update_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
            hold_count <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no expectation pos=%h", $realtime,
                             out_ch.out_position);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    n_checked++;
                    if (want.pos !== out_ch.out_position)
                    begin
                        errors++;
                        $display("%0t: position expected %h actual %h", $realtime,
                                 want.pos, out_ch.out_position);
                    end
                    if (want.vel !== out_ch.out_velocity)
                    begin
                        errors++;
                        $display("%0t: velocity expected %h actual %h", $realtime,
                                 want.vel, out_ch.out_velocity);
                    end
                    if (want.pair !== out_ch.out_pair_force)
                    begin
                        errors++;
                        $display("%0t: pair force expected %h actual %h", $realtime,
                                 want.pair, out_ch.out_pair_force);
                    end
                    if (want.triple !== out_ch.out_triple_force)
                    begin
                        errors++;
                        $display("%0t: triple force expected %h actual %h", $realtime,
                                 want.triple, out_ch.out_triple_force);
                    end
                    if (want.prev !== out_ch.out_previous_force)
                    begin
                        errors++;
                        $display("%0t: previous force expected %h actual %h", $realtime,
                                 want.prev, out_ch.out_previous_force);
                    end
                end
            end
            if (hold_off_req && hold_count < 200)
            begin
                hold_count <= hold_count + 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready && $urandom_range(0, 3) == 0)
                begin
                    stall_left <= $urandom_range(0, 7);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (pending_items.size() == 0 && expected_updates.size() == 0)
            || (hold_off_req && hold_count < 200))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        particle_t it;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.axis = 2'd0;
        in_ch.skip = 1'b0;
        in_ch.mass = '0;
        in_ch.in_position = '0;
        in_ch.in_velocity = '0;
        in_ch.in_pair_force = '0;
        in_ch.in_triple_force = '0;
        in_ch.in_previous_force = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        n_sent = 0;
        n_checked = 0;
        hold_off_req = 0;
        step_dt = '0;
        three_body_on = 0;
        n_respa = '0;
        outer_on = 0;
        global_f[0] = '0;
        global_f[1] = '0;
        global_f[2] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, then extremes, every mode and axis
        write_reg(REG_TIME_STEP, 64'h0000_0000_1000_0000);
        write_reg(REG_GLOBAL_X, SMAX);
        write_reg(REG_GLOBAL_Y, SMIN);
        write_reg(REG_GLOBAL_Z, 64'hFFFF_FFFF_8000_0000);
        for (int k = 0; k < 16; k++)
        begin
            it.mode = k[0];
            it.axis = k[2:1];
            it.skip = (k == 15);
            it.mass = (k == 4 || k == 5) ? '0 : (k[3] ? '1 : {31'd0, 32'd1});
            it.pos = k[3] ? SMAX : SMIN;
            it.vel = k[2] ? SMIN : SMAX;
            it.pair = k[1] ? SMAX : 64'h0000_0001_0000_0000;
            it.triple = k[3] ? SMIN : 64'hFFFF_FFFF_0000_0000;
            it.prev = k[0] ? SMAX : 64'd0;
            pending_items.push_back(it);
        end
        wait_drained();
        write_reg(REG_THREE_BODY, 64'd1);
        write_reg(REG_RESPA_STEPS, 64'd1024);
        write_reg(REG_TIME_STEP, {1'b0, {63{1'b1}}});
        run_batch(5);
        write_reg(REG_OUTER_RESPA, 64'd1);
        write_reg(REG_RESPA_STEPS, 64'd2047);
        run_batch(5);

        // random phases through several settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_TIME_STEP, ph == 0 ? 64'd0 : (ph == 7 ? {1'b0, {63{1'b1}}}
                       : {32'd0, $urandom_range(0, 32'h4000_0000)}));
            write_reg(REG_THREE_BODY, 64'($urandom_range(0, 1)));
            write_reg(REG_RESPA_STEPS, ph[0] ? 64'($urandom_range(0, 2047)) : 64'd0);
            write_reg(REG_OUTER_RESPA, 64'($urandom_range(0, 1)));
            write_reg(REG_GLOBAL_X, rand_word());
            write_reg(REG_GLOBAL_Y, rand_word());
            write_reg(REG_GLOBAL_Z, rand_word());
            if (ph == 3)
            begin
                hold_off_req = 1;
            end
            // the held batch is longer than the pipeline so the input stalls
            run_batch(ph == 3 ? 150 : 64);
            hold_off_req = 0;
        end

        $display("sent %0d particle components, checked %0d updates", n_sent, n_checked);
        $display("covered position and velocity phases, respa modes, zero mass and saturation");
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
src/vvr_pkg.sv
src/vvr_in_if.sv
src/vvr_out_if.sv
src/velocity_verlet_respa_particle_update.sv
verif/tb_velocity_verlet_respa_particle_update.sv
